// ===== design/fcb_pkg.sv =====
// Package for the floppy read command builder: widths, media and byte codes,
// the queued job type and the geometry/reciprocal lookup functions.
// No dependencies.
package fcb_pkg;

    localparam int BlkW       = 13;
    localparam int CylW       = 8;
    localparam int SptW       = 6;
    localparam int QuoW       = 10;
    localparam int RecipW     = 13;
    localparam int RecipShift = 16;
    localparam int MediaW     = 4;
    localparam int CfgIdxW    = 1;
    localparam int ByteW      = 8;
    localparam int StepW      = 4;
    localparam int QueueDepth = 2;  // power of two
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int ProdW      = BlkW + RecipW;
    localparam int BackW      = QuoW + SptW;

    // media codes
    localparam logic [MediaW-1:0] MEDIA_NONE  = 4'd0;
    localparam logic [MediaW-1:0] MEDIA_360K  = 4'd1;
    localparam logic [MediaW-1:0] MEDIA_1200K = 4'd2;
    localparam logic [MediaW-1:0] MEDIA_720K  = 4'd3;
    localparam logic [MediaW-1:0] MEDIA_1440K = 4'd4;
    localparam logic [MediaW-1:0] MEDIA_2880K = 4'd5;

    // register indexes
    localparam logic [CfgIdxW-1:0] CFG_DRIVE0 = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_DRIVE1 = 1'b1;

    // byte positions in the full seek + read run
    localparam logic [StepW-1:0] POS_SEEK_OP   = 4'd0;
    localparam logic [StepW-1:0] POS_SEEK_SEL  = 4'd1;
    localparam logic [StepW-1:0] POS_SEEK_CYL  = 4'd2;
    localparam logic [StepW-1:0] POS_READ_OP   = 4'd3;
    localparam logic [StepW-1:0] POS_READ_SEL  = 4'd4;
    localparam logic [StepW-1:0] POS_READ_CYL  = 4'd5;
    localparam logic [StepW-1:0] POS_READ_HEAD = 4'd6;
    localparam logic [StepW-1:0] POS_READ_SEC  = 4'd7;
    localparam logic [StepW-1:0] POS_READ_SIZE = 4'd8;
    localparam logic [StepW-1:0] POS_READ_EOT  = 4'd9;
    localparam logic [StepW-1:0] POS_READ_GAP  = 4'd10;
    localparam logic [StepW-1:0] POS_READ_DTL  = 4'd11;

    // controller bytes
    localparam logic [ByteW-1:0] OP_SEEK  = 8'h0F;
    localparam logic [ByteW-1:0] OP_READ  = 8'h66;
    localparam logic [ByteW-1:0] SIZE_512 = 8'h02;
    localparam logic [ByteW-1:0] GAP_LEN  = 8'h1B;
    localparam logic [ByteW-1:0] DTL_NONE = 8'hFF;
    localparam logic [ByteW-1:0] ERR_BYTE = 8'h00;

    typedef struct packed {
        logic            err;
        logic            seek;
        logic            drive;
        logic            head;
        logic [CylW-1:0] cyl;
        logic [SptW-1:0] sec;
        logic [SptW-1:0] spt;
    } fcb_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fcb_qstat_t;

    // sectors per track; zero marks none or unknown media
    function automatic logic [SptW-1:0] spt_of(input logic [MediaW-1:0] media);
        logic [SptW-1:0] spt;
        unique case (media)
            MEDIA_360K:  spt = 6'd9;
            MEDIA_1200K: spt = 6'd15;
            MEDIA_720K:  spt = 6'd9;
            MEDIA_1440K: spt = 6'd18;
            MEDIA_2880K: spt = 6'd36;
            default:     spt = '0;
        endcase
        return spt;
    endfunction

    // floor(2^RecipShift / spt); quotient comes out low by at most one
    function automatic logic [RecipW-1:0] recip_of(input logic [SptW-1:0] spt);
        logic [RecipW-1:0] r;
        unique case (spt)
            6'd9:    r = 13'd7281;
            6'd15:   r = 13'd4369;
            6'd18:   r = 13'd3640;
            6'd36:   r = 13'd1820;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/fcb_if.sv =====
// Valid/ready channel interfaces: read requests in, command bytes out.
// Depends on fcb_pkg.
interface fcb_req_if;
    import fcb_pkg::*;
    logic            valid;
    logic            ready;
    logic            drive;
    logic [BlkW-1:0] block_addr;

    modport source (output valid, drive, block_addr, input ready);
    modport sink (input valid, drive, block_addr, output ready);
endinterface

interface fcb_byte_if;
    import fcb_pkg::*;
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] cmd_byte;
    logic             last;
    logic             error;

    modport source (output valid, cmd_byte, last, error, input ready);
    modport sink (input valid, cmd_byte, last, error, output ready);
endinterface

// ===== design/floppy_read_command_builder.sv =====
// Top level of the floppy read command builder: front end, job queue and
// byte sequencer. Depends on fcb_pkg, fcb_if, fcb_front, fcb_queue, fcb_back.
//
//  channel  dir  payload                      transfer when
//  req      in   drive, block_addr            req.valid & req.ready
//  rsp      out  cmd_byte, last, error        rsp.valid & rsp.ready
//  cfg      in   cfg_index, cfg_data          cfg_we
//
// A request passes through the front pipeline into the job queue, and the
// sequencer registers its bytes out from the queue head.
// The sequencer then sends one byte per cycle while rsp.ready is high:
// 12 bytes for seek + read, 9 for a read alone, 1 for an error; that byte
// run sets the sustained rate. Requests keep being taken while bytes drain,
// until the two-entry queue and both front stages are full.
// rst_n clears drive types to none and marks all cylinders unknown.
module floppy_read_command_builder (
    input  logic                         clk,
    input  logic                         rst_n,
    fcb_req_if.sink                      req,
    fcb_byte_if.source                   rsp,
    input  logic                         cfg_we,
    input  logic [fcb_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [fcb_pkg::MediaW-1:0]   cfg_data
);
    import fcb_pkg::*;

    fcb_job_t   job_in;
    fcb_job_t   job_out;
    fcb_qstat_t qstat;
    logic       push;
    logic       pop;

    fcb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .qstat     (qstat),
        .push      (push),
        .job       (job_in)
    );

    fcb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (job_in),
        .pop     (pop),
        .job_out (job_out),
        .qstat   (qstat)
    );

    fcb_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .job   (job_out),
        .qstat (qstat),
        .pop   (pop),
        .rsp   (rsp)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("job queue underflow");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.error) |-> (rsp.last && rsp.cmd_byte == ERR_BYTE))
        else $error("error result not a single zero byte");

    a_seek_then_read: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready && !rsp.error && rsp.cmd_byte == OP_SEEK && !rsp.last)
        |=> (rsp.valid && !rsp.last))
        else $error("seek run cut short");
`endif

endmodule

// ===== design/fcb_front.sv =====
// Front end: drive type registers, two-stage geometry pipeline (reciprocal
// multiply, remainder correction) and the per drive/head cylinder tracker.
// Depends on fcb_pkg, fcb_if.
module fcb_front (
    input  logic                         clk,
    input  logic                         rst_n,
    fcb_req_if.sink                      req,
    input  logic                         cfg_we,
    input  logic [fcb_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [fcb_pkg::MediaW-1:0]   cfg_data,
    input  fcb_pkg::fcb_qstat_t          qstat,
    output logic                         push,
    output fcb_pkg::fcb_job_t            job
);
    import fcb_pkg::*;

    logic [MediaW-1:0] drive0_type_reg;
    logic [MediaW-1:0] drive1_type_reg;

    logic              s1_valid_reg;
    logic              s1_drive_reg;
    logic [BlkW-1:0]   s1_blk_reg;
    logic [SptW-1:0]   s1_spt_reg;

    logic              s2_valid_reg;
    logic              s2_drive_reg;
    logic [BlkW-1:0]   s2_blk_reg;
    logic [SptW-1:0]   s2_spt_reg;
    logic [QuoW-1:0]   s2_quo0_reg;

    logic [CylW-1:0]   cur_cyl_reg [4];
    logic [3:0]        known_reg;

    logic              s1_free;
    logic              s1_adv;
    logic              s2_free;
    logic              accept;
    logic [MediaW-1:0] media;
    logic [ProdW-1:0]  prod1;
    logic [BackW-1:0]  back_prod;
    logic [BackW-1:0]  rem0;
    logic              corr;
    logic [QuoW-1:0]   quo;
    logic [BackW-1:0]  rem;
    logic [CylW-1:0]   cyl;
    logic              head;
    logic [1:0]        idx;
    logic              err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive0_type_reg <= MEDIA_NONE;
            drive1_type_reg <= MEDIA_NONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DRIVE0: drive0_type_reg <= cfg_data;
                CFG_DRIVE1: drive1_type_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign push    = s2_valid_reg && !qstat.full;
    assign s2_free = !s2_valid_reg || push;
    assign s1_adv  = s1_valid_reg && s2_free;
    assign s1_free = !s1_valid_reg || s1_adv;
    assign req.ready = s1_free;
    assign accept  = req.valid && s1_free;
    assign media   = req.drive ? drive1_type_reg : drive0_type_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= req.valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_drive_reg <= req.drive;
            s1_blk_reg   <= req.block_addr;
            s1_spt_reg   <= spt_of(media);
        end
        if (s1_adv)
        begin
            s2_drive_reg <= s1_drive_reg;
            s2_blk_reg   <= s1_blk_reg;
            s2_spt_reg   <= s1_spt_reg;
            s2_quo0_reg  <= prod1[RecipShift +: QuoW];
        end
    end

    // quotient estimate by reciprocal
    assign prod1 = {{RecipW{1'b0}}, s1_blk_reg} * {{BlkW{1'b0}}, recip_of(s1_spt_reg)};

    // remainder and one-step correction
    always_comb
    begin
        back_prod = {{SptW{1'b0}}, s2_quo0_reg} * {{QuoW{1'b0}}, s2_spt_reg};
        rem0      = {{(BackW - BlkW){1'b0}}, s2_blk_reg} - back_prod;
        corr      = rem0 >= {{QuoW{1'b0}}, s2_spt_reg};
        quo       = s2_quo0_reg + {{(QuoW - 1){1'b0}}, corr};
        rem       = corr ? rem0 - {{QuoW{1'b0}}, s2_spt_reg} : rem0;
        cyl       = quo[CylW:1];
        head      = quo[0];
        idx       = {s2_drive_reg, head};
        err       = (s2_spt_reg == '0);

        job.err   = err;
        job.seek  = !known_reg[idx] || (cur_cyl_reg[idx] != cyl);
        job.drive = s2_drive_reg;
        job.head  = head;
        job.cyl   = cyl;
        job.sec   = rem[SptW-1:0] + 6'd1;
        job.spt   = s2_spt_reg;
    end

    // seek is assumed to succeed once queued
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_reg <= '0;
            for (int i = 0; i < 4; i++)
                cur_cyl_reg[i] <= '0;
        end
        else if (push && !err)
        begin
            known_reg[idx]   <= 1'b1;
            cur_cyl_reg[idx] <= cyl;
        end
    end

endmodule

// ===== design/fcb_queue.sv =====
// Short job queue between the front end and the byte sequencer.
// Depends on fcb_pkg.
module fcb_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  fcb_pkg::fcb_job_t    job_in,
    input  logic                 pop,
    output fcb_pkg::fcb_job_t    job_out,
    output fcb_pkg::fcb_qstat_t  qstat
);
    import fcb_pkg::*;

    fcb_job_t         mem_reg [QueueDepth];
    logic [QPtrW-1:0] wr_ptr_reg;
    logic [QPtrW-1:0] rd_ptr_reg;
    logic [QPtrW:0]   count_reg;

    assign qstat.full  = (count_reg == (QPtrW + 1)'(QueueDepth));
    assign qstat.empty = (count_reg == '0);
    assign job_out     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= job_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

// ===== design/fcb_back.sv =====
// Byte sequencer: walks the queue head through its seek/read byte run and
// drives the registered output channel, one byte per transfer.
// Depends on fcb_pkg, fcb_if.
module fcb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fcb_pkg::fcb_job_t    job,
    input  fcb_pkg::fcb_qstat_t  qstat,
    output logic                 pop,
    fcb_byte_if.source           rsp
);
    import fcb_pkg::*;

    logic             out_valid_reg;
    logic [ByteW-1:0] cmd_reg;
    logic             last_reg;
    logic             error_reg;
    logic [StepW-1:0] step_reg;

    logic             load;
    logic [StepW-1:0] pos;
    logic [ByteW-1:0] sel;
    logic [ByteW-1:0] byte_next;
    logic             last_next;

    assign load = !qstat.empty && (!out_valid_reg || rsp.ready);
    assign pos  = job.seek ? step_reg : step_reg + POS_READ_OP;
    assign sel  = {5'b0, job.head, 1'b0, job.drive};

    always_comb
    begin
        unique case (pos)
            POS_SEEK_OP:   byte_next = OP_SEEK;
            POS_SEEK_SEL:  byte_next = sel;
            POS_SEEK_CYL:  byte_next = job.cyl;
            POS_READ_OP:   byte_next = OP_READ;
            POS_READ_SEL:  byte_next = sel;
            POS_READ_CYL:  byte_next = job.cyl;
            POS_READ_HEAD: byte_next = {7'b0, job.head};
            POS_READ_SEC:  byte_next = {2'b0, job.sec};
            POS_READ_SIZE: byte_next = SIZE_512;
            POS_READ_EOT:  byte_next = {2'b0, job.spt};
            POS_READ_GAP:  byte_next = GAP_LEN;
            POS_READ_DTL:  byte_next = DTL_NONE;
            default:       byte_next = ERR_BYTE;
        endcase
        if (job.err)
            byte_next = ERR_BYTE;
        last_next = job.err || (pos == POS_READ_DTL);
    end

    assign pop = load && last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if (!out_valid_reg || rsp.ready)
                out_valid_reg <= !qstat.empty;
            if (load)
                step_reg <= last_next ? '0 : step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg   <= byte_next;
            last_reg  <= last_next;
            error_reg <= job.err;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.cmd_byte = cmd_reg;
    assign rsp.last     = last_reg;
    assign rsp.error    = error_reg;

endmodule

// ===== tb/fcb_command_checker.sv =====
`timescale 1ns / 1ps
// Command byte checker for the floppy read command builder: watches the request,
// byte and register ports, predicts every controller byte and compares in order.
// Depends on fcb_pkg and the channel interfaces in fcb_if.
module fcb_command_checker
    import fcb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    fcb_req_if                 req,
    fcb_byte_if                rsp,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [MediaW-1:0]  cfg_data,
    output int                 mismatches,
    output int                 outstanding,
    output int                 requests_seen,
    output int                 seeks_seen,
    output int                 refusals_seen,
    output int                 bytes_checked
);

    typedef struct packed {
        logic [ByteW-1:0] cmd_byte;
        logic             last;
        logic             error;
    } cmd_byte_t;

    logic [MediaW-1:0] media [2];
    logic [CylW-1:0]   head_cyl [4];
    logic              cyl_known [4];
    cmd_byte_t         expected_bytes [$];
    cmd_byte_t         got;
    cmd_byte_t         want;
    int                n_mismatch;
    int                n_req;
    int                n_seek;
    int                n_refuse;
    int                n_bytes;

    function automatic void push_byte(input logic [ByteW-1:0] b, input logic last,
                                      input logic err);
        cmd_byte_t entry;
        entry.cmd_byte = b;
        entry.last     = last;
        entry.error    = err;
        expected_bytes.push_back(entry);
    endfunction

    task automatic predict_command_bytes(input logic drv, input logic [BlkW-1:0] blk);
        int unsigned      spt;
        int unsigned      blk_u;
        logic             hd;
        logic [CylW-1:0]  cyl;
        logic [ByteW-1:0] sel;
        logic [1:0]       slot;
        blk_u = blk;
        case (media[drv]) inside
            MEDIA_360K, MEDIA_720K: spt = 9;
            MEDIA_1200K:            spt = 15;
            MEDIA_1440K:            spt = 18;
            MEDIA_2880K:            spt = 36;
            default:                spt = 0;
        endcase
        n_req++;
        if (spt == 0)
        begin
            push_byte(ERR_BYTE, 1'b1, 1'b1);
            n_refuse++;
        end
        else
        begin
            cyl  = CylW'(blk_u / (2 * spt));
            hd   = ((blk_u / spt) % 2) != 0;
            sel  = ByteW'({hd, 1'b0, drv});
            slot = {drv, hd};
            if (!cyl_known[slot] || head_cyl[slot] != cyl)
            begin
                push_byte(OP_SEEK, 1'b0, 1'b0);
                push_byte(sel, 1'b0, 1'b0);
                push_byte(cyl, 1'b0, 1'b0);
                head_cyl[slot]  = cyl;
                cyl_known[slot] = 1'b1;
                n_seek++;
            end
            push_byte(OP_READ, 1'b0, 1'b0);
            push_byte(sel, 1'b0, 1'b0);
            push_byte(cyl, 1'b0, 1'b0);
            push_byte(ByteW'(hd), 1'b0, 1'b0);
            push_byte(ByteW'(blk_u % spt + 1), 1'b0, 1'b0);
            push_byte(SIZE_512, 1'b0, 1'b0);
            push_byte(ByteW'(spt), 1'b0, 1'b0);
            push_byte(GAP_LEN, 1'b0, 1'b0);
            push_byte(DTL_NONE, 1'b1, 1'b0);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            media[0] = MEDIA_NONE;
            media[1] = MEDIA_NONE;
            for (int i = 0; i < 4; i++)
            begin
                head_cyl[i]  = '0;
                cyl_known[i] = 1'b0;
            end
            expected_bytes.delete();
            n_mismatch = 0;
            n_req      = 0;
            n_seek     = 0;
            n_refuse   = 0;
            n_bytes    = 0;
        end
        else
        begin
            if (cfg_we)
                media[cfg_index == CFG_DRIVE1] = cfg_data;
            if (req.valid && req.ready)
                predict_command_bytes(req.drive, req.block_addr);
            if (rsp.valid && rsp.ready)
            begin
                got.cmd_byte = rsp.cmd_byte;
                got.last     = rsp.last;
                got.error    = rsp.error;
                n_bytes++;
                if (expected_bytes.size() == 0)
                begin
                    if (n_mismatch < 10)
                        $display("%0t: unexpected byte %h last %b error %b", $realtime,
                                 got.cmd_byte, got.last, got.error);
                    n_mismatch++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (got !== want)
                    begin
                        if (n_mismatch < 10)
                            $display("%0t: expected %h/%b/%b, got %h/%b/%b (byte/last/error)",
                                     $realtime, want.cmd_byte, want.last, want.error,
                                     got.cmd_byte, got.last, got.error);
                        n_mismatch++;
                    end
                end
            end
        end
        mismatches    <= n_mismatch;
        outstanding   <= expected_bytes.size();
        requests_seen <= n_req;
        seeks_seen    <= n_seek;
        refusals_seen <= n_refuse;
        bytes_checked <= n_bytes;
    end

endmodule

// ===== tb/tb_floppy_read_command_builder.sv =====
`timescale 1ns / 1ps
// Testbench top for the floppy read command builder: clock, reset, request and
// media stimulus, output stalls, watchdog and verdict.
// Depends on fcb_pkg, fcb_if, the block itself and fcb_command_checker.
module tb_floppy_read_command_builder;
    import fcb_pkg::*;

    localparam int RX_HOLD_CYCLES = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASE_ITEMS    = 36;
    localparam logic [MediaW-1:0] MEDIA_BAD_LOW  = 4'd6;
    localparam logic [MediaW-1:0] MEDIA_BAD_HIGH = 4'd15;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [MediaW-1:0]  cfg_data;

    fcb_req_if  req_ch ();
    fcb_byte_if rsp_ch ();

    int mismatches;
    int outstanding;
    int requests_seen;
    int seeks_seen;
    int refusals_seen;
    int bytes_checked;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_seq  = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;
    int quiet_cycles = 0;

    floppy_read_command_builder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fcb_command_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .requests_seen (requests_seen),
        .seeks_seen    (seeks_seen),
        .refusals_seen (refusals_seen),
        .bytes_checked (bytes_checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // byte sink: random stalls plus a long hold-off when requested
    always @(posedge clk)
    begin
        if (rx_hold_seen != rx_hold_seq)
        begin
            rx_hold_seen <= rx_hold_seq;
            rx_hold_left <= RX_HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end
        else if (rx_hold_left != 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $realtime, quiet_cycles);
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_request(input logic drv, input logic [BlkW-1:0] blk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.drive      <= drv;
        req_ch.block_addr <= blk;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_until_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_media(input logic [MediaW-1:0] m0, input logic [MediaW-1:0] m1);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DRIVE0;
        cfg_data  <= m0;
        @(posedge clk);
        cfg_index <= CFG_DRIVE1;
        cfg_data  <= m1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [MediaW-1:0] pick_media();
        if ($urandom_range(9) < 8)
            return MediaW'($urandom_range(MEDIA_2880K, MEDIA_360K));
        return MediaW'($urandom_range(MEDIA_BAD_HIGH));
    endfunction

    // mostly runs of consecutive sectors so most reads skip the seek
    task automatic random_phase(input int n_items);
        int               sent;
        int               run_len;
        logic             drv;
        logic [BlkW-1:0]  start;
        sent = 0;
        while (sent < n_items)
        begin
            drv     = 1'($urandom_range(1));
            start   = BlkW'($urandom_range(8191));
            run_len = ($urandom_range(3) == 0) ? 1 : $urandom_range(8, 2);
            for (int i = 0; i < run_len; i++)
                send_request(drv, start + BlkW'(i));
            sent += run_len;
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.drive      = 1'b0;
        req_ch.block_addr = '0;
        rsp_ch.ready      = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_DRIVE0;
        cfg_data          = MEDIA_NONE;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no media after reset
        send_request(1'b0, '0);
        send_request(1'b1, 13'd8191);
        wait_until_idle();

        set_media(MEDIA_2880K, MEDIA_BAD_HIGH);
        send_request(1'b1, '0);
        send_request(1'b0, '0);
        send_request(1'b0, '0);
        send_request(1'b0, 13'd35);
        send_request(1'b0, 13'd36);
        send_request(1'b0, 13'd8191);
        wait_until_idle();

        // cylinder wrap: 4608 lands on the recorded cylinder 0
        set_media(MEDIA_360K, MEDIA_BAD_LOW);
        send_request(1'b0, '0);
        send_request(1'b0, 13'd4608);
        send_request(1'b0, 13'd8191);
        send_request(1'b1, 13'd5);
        wait_until_idle();

        set_media(MEDIA_1200K, MEDIA_720K);
        send_request(1'b1, '0);
        send_request(1'b1, 13'd8191);
        send_request(1'b0, 13'd29);
        send_request(1'b0, 13'd30);
        wait_until_idle();

        set_media(MEDIA_1440K, MEDIA_1440K);
        send_request(1'b0, 13'd8191);
        send_request(1'b1, 13'd4607);
        send_request(1'b1, 13'd4608);
        wait_until_idle();

        // no idling, with one long output hold to back up the input
        set_media(pick_media(), pick_media());
        rx_hold_seq <= rx_hold_seq + 1;
        random_phase(PHASE_ITEMS);
        wait_until_idle();

        set_media(pick_media(), pick_media());
        tx_idle_pct = 66;
        random_phase(PHASE_ITEMS);
        wait_until_idle();

        set_media(pick_media(), pick_media());
        tx_idle_pct = 0;
        rx_stall_pct <= 66;
        random_phase(PHASE_ITEMS);
        wait_until_idle();

        set_media(pick_media(), pick_media());
        tx_idle_pct = 11;
        rx_stall_pct <= 11;
        random_phase(PHASE_ITEMS);
        wait_until_idle();

        $display("Covered %0d read requests (%0d needing a seek, %0d refused for bad media),",
                 requests_seen, seeks_seen, refusals_seen);
        $display("%0d command bytes checked over all media types and four idling patterns.",
                 bytes_checked);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
design/fcb_pkg.sv
design/fcb_if.sv
design/fcb_front.sv
design/fcb_queue.sv
design/fcb_back.sv
design/floppy_read_command_builder.sv
tb/fcb_command_checker.sv
tb/tb_floppy_read_command_builder.sv
